/* sv/rrt_pkg.sv */
// ----------------------------------------------------------------------------
// rrt_pkg
// Shared types and codes for the retransmit tracker: operation and result
// kinds, beat field widths and the packed layout of one table entry.
// ----------------------------------------------------------------------------
`default_nettype none

package rrt_pkg;

  localparam int CHAN_W  = 32;
  localparam int LINK_W  = 3;
  localparam int ADDR_W  = 32;
  localparam int MSG_W   = 64;
  localparam int ATT_W   = 8;
  localparam int TIME_W  = 32;
  localparam int SLOT_W  = 4;
  localparam int OP_W    = 2;
  localparam int KIND_W  = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 168;
  localparam int OUT_DATA_W = 144;

  typedef logic [OP_W-1:0]   op_t;
  typedef logic [KIND_W-1:0] kind_t;

  localparam op_t OP_TRACK  = 2'd0;
  localparam op_t OP_ACK    = 2'd1;
  localparam op_t OP_CANCEL = 2'd2;
  localparam op_t OP_TICK   = 2'd3;

  localparam kind_t K_TRACKED   = 3'd0;
  localparam kind_t K_FULL      = 3'd1;
  localparam kind_t K_RELEASED  = 3'd2;
  localparam kind_t K_NO_MATCH  = 3'd3;
  localparam kind_t K_CANCELLED = 3'd4;
  localparam kind_t K_RESEND    = 3'd5;
  localparam kind_t K_ABANDONED = 3'd6;
  localparam kind_t K_TICK_DONE = 3'd7;

  localparam logic [CFG_IDX_W-1:0] CFG_RETRY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTEMPTS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINKMASK = 2'd2;

  typedef struct packed {
    logic [CHAN_W-1:0] channel;
    logic [LINK_W-1:0] link;
    logic [ADDR_W-1:0] address;
    logic [MSG_W-1:0]  msg_id;
    logic [ATT_W-1:0]  attempts;
    logic [TIME_W-1:0] last_time;
  } entry_t;

endpackage

`default_nettype wire

/* sv/rrt_ram.sv */
// ----------------------------------------------------------------------------
// rrt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* sv/reliable_retransmit_tracker_core.sv */
// A track beat scans the valid bits one slot per cycle until it finds a free
// slot; ack, cancel and tick beats visit each slot with an entry RAM read
// state and then an evaluate state.
// One beat is processed at a time; results wait only for a free output register.
// Reset (synchronous, rst_n low) clears valid bits, id, time and abandon
// counters and restores configuration defaults; entry RAM is not cleared.
// ----------------------------------------------------------------------------
// reliable_retransmit_tracker_core
// Table of pending reliable messages with ack matching, channel cancel and a
// retry timer walk, driven by a small sequencer over one shared entry RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module reliable_retransmit_tracker_core #(
  parameter int TABLE_DEPTH = 16,
  parameter int LINK_COUNT  = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // configuration write port
  input  wire logic                               cfg_we,
  input  wire logic [rrt_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  wire logic [rrt_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // input stream
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // tdata, low bit up: channel_id[31:0], link_id[34:32], route_address[66:35],
  // ack_message_id[130:67], now_ms[162:131], zero pad[167:163]
  input  wire logic [rrt_pkg::IN_DATA_W-1:0]      in_tdata,
  // tuser: op[1:0]
  input  wire logic [rrt_pkg::OP_W-1:0]           in_tuser,
  // result stream
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // tdata, low bit up: slot_index[3:0], msg_id_out[67:4], link_out[70:68],
  // address_out[102:71], attempts_out[110:103], abandoned_total[142:111],
  // zero pad[143]
  output logic      [rrt_pkg::OUT_DATA_W-1:0]     out_tdata,
  // tuser: kind[2:0]
  output logic      [rrt_pkg::KIND_W-1:0]         out_tuser,
  // tlast: last_of_run
  output logic                                    out_tlast
);

  import rrt_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int ENT_W = $bits(entry_t);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_EV   = 2'd2;
  localparam logic [1:0] ST_END  = 2'd3;

  // Configuration registers.
  logic [TIME_W-1:0] retry_r;
  logic [ATT_W-1:0]  max_att_r;
  logic [7:0]        link_mask_r;

  // Sequencer and table state.
  logic [1:0]             state_r, state_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [TABLE_DEPTH-1:0] valid_r, valid_nxt;
  logic [MSG_W-1:0]       next_id_r, next_id_nxt;
  logic [TIME_W-1:0]      recent_r, recent_nxt;
  logic [31:0]            aband_r, aband_nxt;

  // Latched input beat.
  op_t               op_r;
  logic [CHAN_W-1:0] chan_r;
  logic [LINK_W-1:0] link_r;
  logic [ADDR_W-1:0] addr_r;
  logic [MSG_W-1:0]  ack_r;
  logic [TIME_W-1:0] now_r;

  // Output register.
  logic                out_valid_r;
  kind_t               o_kind_r;
  logic [SLOT_W-1:0]   o_slot_r;
  logic [MSG_W-1:0]    o_msg_r;
  logic [LINK_W-1:0]   o_link_r;
  logic [ADDR_W-1:0]   o_addr_r;
  logic [ATT_W-1:0]    o_att_r;
  logic [31:0]         o_aband_r;
  logic                o_last_r;

  // Entry RAM.
  logic             ram_we;
  entry_t           ram_wdata;
  logic [ENT_W-1:0] ram_rdata;
  entry_t           ent;

  rrt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (ram_wdata),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  assign ent = entry_t'(ram_rdata);

  // Emission request toward the output register.
  logic              emit, emit_last;
  kind_t             emit_kind;
  logic [SLOT_W-1:0] emit_slot;
  logic [MSG_W-1:0]  emit_msg;
  logic [LINK_W-1:0] emit_link;
  logic [ADDR_W-1:0] emit_addr;
  logic [ATT_W-1:0]  emit_att;
  logic [31:0]       emit_aband;

  logic out_free;
  logic accept;
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  // The slot under evaluation, as seen from the RAM read data.
  logic              ack_hit, chan_hit, time_ok, elapsed, link_ok, give_up;
  logic [TIME_W-1:0] age;
  logic              slot_valid;

  assign slot_valid = valid_r[idx_r];
  assign chan_hit   = slot_valid && (ent.channel == chan_r);
  assign ack_hit    = chan_hit && (ent.link == link_r) && (ent.address == addr_r)
                      && (ent.msg_id == ack_r);
  assign time_ok    = slot_valid && (now_r >= ent.last_time);
  assign age        = now_r - ent.last_time;
  assign elapsed    = time_ok && (age >= retry_r);
  // A link is present only below the link count and with its mask bit set.
  assign link_ok    = ({1'b0, ent.link} < 4'(LINK_COUNT)) && link_mask_r[ent.link];
  assign give_up    = (ent.attempts >= max_att_r) || !link_ok;

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    valid_nxt   = valid_r;
    next_id_nxt = next_id_r;
    recent_nxt  = recent_r;
    aband_nxt   = aband_r;
    ram_we      = 1'b0;
    ram_wdata   = ent;
    emit        = 1'b0;
    emit_last   = 1'b0;
    emit_kind   = K_TICK_DONE;
    emit_slot   = SLOT_W'(idx_r);
    emit_msg    = '0;
    emit_link   = '0;
    emit_addr   = '0;
    emit_att    = '0;
    emit_aband  = aband_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          idx_nxt = '0;
          if (in_tuser == OP_TRACK && (&next_id_r)) begin
            state_nxt = ST_END;
          end else begin
            state_nxt = ST_RD;
          end
          if (in_tuser == OP_TICK) begin
            recent_nxt = in_tdata[162:131];
          end
        end
      end

      ST_RD: begin
        // Track needs only the valid bits; the other operations evaluate
        // the entry in the next cycle, when the RAM data is out.
        if (op_r == OP_TRACK) begin
          if (!slot_valid) begin
            if (out_free) begin
              ram_we             = 1'b1;
              ram_wdata.channel  = chan_r;
              ram_wdata.link     = link_r;
              ram_wdata.address  = addr_r;
              ram_wdata.msg_id   = next_id_r;
              ram_wdata.attempts = ATT_W'(1);
              ram_wdata.last_time = recent_r;
              valid_nxt[idx_r]   = 1'b1;
              next_id_nxt        = next_id_r + MSG_W'(1);
              emit      = 1'b1;
              emit_last = 1'b1;
              emit_kind = K_TRACKED;
              emit_msg  = next_id_r;
              emit_link = link_r;
              emit_addr = addr_r;
              emit_att  = ATT_W'(1);
              state_nxt = ST_IDLE;
            end
          end else if (idx_r == LAST_IDX) begin
            state_nxt = ST_END;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end else begin
          state_nxt = ST_EV;
        end
      end

      ST_EV: begin
        logic act;
        logic done;
        act  = 1'b0;
        done = 1'b0;
        case (op_r)
          OP_ACK: begin
            if (ack_hit) begin
              act = 1'b1;
              if (out_free) begin
                valid_nxt[idx_r] = 1'b0;
                emit      = 1'b1;
                emit_last = 1'b1;
                emit_kind = K_RELEASED;
                emit_msg  = ent.msg_id;
                emit_link = ent.link;
                emit_addr = ent.address;
                emit_att  = ent.attempts;
                done      = 1'b1;
              end
            end
          end
          OP_CANCEL: begin
            if (chan_hit) begin
              valid_nxt[idx_r] = 1'b0;
            end
          end
          default: begin
            if (elapsed) begin
              act = 1'b1;
              if (out_free) begin
                emit      = 1'b1;
                emit_msg  = ent.msg_id;
                emit_link = ent.link;
                emit_addr = ent.address;
                if (give_up) begin
                  valid_nxt[idx_r] = 1'b0;
                  aband_nxt  = aband_r + 32'd1;
                  emit_kind  = K_ABANDONED;
                  emit_att   = ent.attempts;
                  emit_aband = aband_r + 32'd1;
                end else begin
                  ram_we              = 1'b1;
                  ram_wdata.attempts  = ent.attempts + ATT_W'(1);
                  ram_wdata.last_time = now_r;
                  emit_kind = K_RESEND;
                  emit_att  = ent.attempts + ATT_W'(1);
                end
              end
            end
          end
        endcase

        if (done) begin
          state_nxt = ST_IDLE;
        end else if (!act || emit) begin
          if (idx_r == LAST_IDX) begin
            state_nxt = ST_END;
          end else begin
            idx_nxt   = idx_r + IDX_W'(1);
            state_nxt = ST_RD;
          end
        end
      end

      ST_END: begin
        // Closing result of the beat: full, no match, cancelled or tick done.
        if (out_free) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          emit_slot = '0;
          case (op_r)
            OP_TRACK:  emit_kind = K_FULL;
            OP_ACK: begin
              emit_kind = K_NO_MATCH;
              emit_msg  = ack_r;
            end
            OP_CANCEL: emit_kind = K_CANCELLED;
            default:   emit_kind = K_TICK_DONE;
          endcase
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      valid_r     <= '0;
      next_id_r   <= '0;
      recent_r    <= '0;
      aband_r     <= '0;
      out_valid_r <= 1'b0;
      retry_r     <= 32'd100;
      max_att_r   <= 8'd3;
      link_mask_r <= 8'd0;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      valid_r   <= valid_nxt;
      next_id_r <= next_id_nxt;
      recent_r  <= recent_nxt;
      aband_r   <= aband_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_RETRY:    retry_r     <= cfg_wdata;
          CFG_ATTEMPTS: max_att_r   <= cfg_wdata[ATT_W-1:0];
          CFG_LINKMASK: link_mask_r <= cfg_wdata[7:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_tuser;
      chan_r <= in_tdata[31:0];
      link_r <= in_tdata[34:32];
      addr_r <= in_tdata[66:35];
      ack_r  <= in_tdata[130:67];
      now_r  <= in_tdata[162:131];
    end
    if (emit) begin
      o_kind_r  <= emit_kind;
      o_slot_r  <= emit_slot;
      o_msg_r   <= emit_msg;
      o_link_r  <= emit_link;
      o_addr_r  <= emit_addr;
      o_att_r   <= emit_att;
      o_aband_r <= emit_aband;
      o_last_r  <= emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = o_kind_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {1'b0, o_aband_r, o_att_r, o_addr_r, o_link_r, o_msg_r, o_slot_r};

  // A beat's final result always returns the sequencer to idle.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && emit_last) |=> (state_r == ST_IDLE))
    else $error("sequencer not idle after final result");

  // At most one slot becomes valid per cycle.
  a_one_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) <= $past($countones(valid_r)) + 1)
    else $error("more than one slot filled at once");

  // A result is loaded only when the output register is free.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (!out_valid_r || out_tready))
    else $error("result register overwritten");

  // The slot walk never leaves the table.
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (idx_r <= LAST_IDX))
    else $error("slot index out of range");

endmodule

`default_nettype wire
